FILE: hw/rtl/c3s2_pkg.sv
package c3s2_pkg;

	localparam int MaxWidthDef = 64;
	localparam int MaxHeightDef = 64;
	localparam int MaxInChDef = 64;
	localparam int MaxOutChDef = 16;
	localparam int SampleBitsDef = 16;
	localparam int Taps = 3 * 3;
	localparam int SumBits = 48;

	// Register indexes on the configuration port.
	localparam logic [2:0] RegInWidth = 3'd0;
	localparam logic [2:0] RegInHeight = 3'd1;
	localparam logic [2:0] RegInCh = 3'd2;
	localparam logic [2:0] RegOutCh = 3'd3;
	localparam logic [2:0] RegOutWidth = 3'd4;
	localparam logic [2:0] RegOutHeight = 3'd5;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SHIFT,
		ST_MAC,
		ST_ACC,
		ST_OUT,
		ST_ADV
	} ctl_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic wr_weight;
		logic pix_load;
		logic shift;
		logic tap_clr;
		logic tap_en;
		logic acc_rd;
		logic acc_wr;
		logic out_load;
		logic advance;
	} ctl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic window;
		logic tap_last;
		logic k_last;
		logic q_last;
		logic out_busy;
	} dp_stat_t;

endpackage

FILE: hw/rtl/c3s2_ctrl.sv
module c3s2_ctrl
	import c3s2_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_action,
	output logic       in_ready,
	input  dp_stat_t   stat,
	output ctl_cmd_t   cmd
);

	ctl_state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && in_action) begin
					state_d = ST_SHIFT;
				end
			end
			ST_SHIFT: state_d = stat.window ? ST_MAC : ST_ADV;
			ST_MAC: begin
				if (stat.tap_last) begin
					state_d = ST_ACC;
				end
			end
			ST_ACC: state_d = stat.q_last ? ST_OUT : (stat.k_last ? ST_ADV : ST_MAC);
			ST_OUT: begin
				if (!stat.out_busy) begin
					state_d = stat.k_last ? ST_ADV : ST_MAC;
				end
			end
			ST_ADV: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.wr_weight = in_valid && !in_action;
				cmd.pix_load = in_valid && in_action;
			end
			ST_SHIFT: begin
				cmd.shift = 1'b1;
				cmd.tap_clr = 1'b1;
			end
			ST_MAC: begin
				cmd.tap_en = 1'b1;
				cmd.acc_rd = 1'b1;
			end
			ST_ACC: begin
				cmd.acc_wr = 1'b1;
				cmd.tap_clr = 1'b1;
			end
			ST_OUT: cmd.out_load = !stat.out_busy;
			ST_ADV: cmd.advance = 1'b1;
			default: ;
		endcase
	end

endmodule

FILE: hw/rtl/c3s2_datapath.sv
module c3s2_datapath
	import c3s2_pkg::*;
#(
	parameter int MAX_WIDTH = MaxWidthDef,
	parameter int MAX_HEIGHT = MaxHeightDef,
	parameter int MAX_IN_CHANNELS = MaxInChDef,
	parameter int MAX_OUT_CHANNELS = MaxOutChDef,
	parameter int SAMPLE_BITS = SampleBitsDef
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ctl_cmd_t                      cmd,
	output dp_stat_t                      stat,
	input  logic [6:0]                    cfg_in_width,
	input  logic [6:0]                    cfg_in_height,
	input  logic [6:0]                    cfg_in_ch,
	input  logic [4:0]                    cfg_out_ch,
	input  logic [4:0]                    cfg_out_width,
	input  logic [4:0]                    cfg_out_height,
	input  logic [3:0]                    weight_out_channel,
	input  logic [5:0]                    weight_in_channel,
	input  logic [3:0]                    weight_tap,
	input  logic signed [SAMPLE_BITS-1:0] weight_value,
	input  logic signed [SAMPLE_BITS-1:0] pixel_value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [3:0]                    out_channel,
	output logic [4:0]                    out_row,
	output logic [4:0]                    out_col,
	output logic signed [SumBits-1:0]     sum_value,
	output logic                          last_of_position,
	output logic                          end_of_frame
);

	localparam int CW = $clog2(MAX_WIDTH + 1);
	localparam int RW = $clog2(MAX_HEIGHT + 1);
	localparam int QW = $clog2(MAX_IN_CHANNELS + 1);
	localparam int KW = $clog2(MAX_OUT_CHANNELS + 1);
	localparam int CIW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int KIW = (MAX_OUT_CHANNELS > 1) ? $clog2(MAX_OUT_CHANNELS) : 1;
	localparam int AC = MAX_WIDTH / 2;
	localparam int AR = MAX_HEIGHT / 2;
	localparam int XW = (AC > 1) ? $clog2(AC) : 1;
	localparam int YW = (AR > 1) ? $clog2(AR) : 1;
	localparam int WDEPTH = MAX_OUT_CHANNELS * MAX_IN_CHANNELS * Taps;
	localparam int WAW = $clog2(WDEPTH);
	localparam int ADEPTH = MAX_OUT_CHANNELS * AR * AC;
	localparam int AAW = $clog2(ADEPTH);
	localparam int PW = 2 * SAMPLE_BITS;

	// Clamped configuration values.
	logic [CW-1:0] iw, ow;
	logic [RW-1:0] ih, oh;
	logic [QW-1:0] ic;
	logic [KW-1:0] oc;
	logic [CW-1:0] owl;
	logic [RW-1:0] ohl;
	always_comb begin
		iw = (cfg_in_width < 7'd3) ? CW'(3) :
			((32'(cfg_in_width) > MAX_WIDTH) ? CW'(MAX_WIDTH) : CW'(cfg_in_width));
		ih = (cfg_in_height < 7'd3) ? RW'(3) :
			((32'(cfg_in_height) > MAX_HEIGHT) ? RW'(MAX_HEIGHT) : RW'(cfg_in_height));
		ic = (cfg_in_ch == 7'd0) ? QW'(1) :
			((32'(cfg_in_ch) > MAX_IN_CHANNELS) ? QW'(MAX_IN_CHANNELS) : QW'(cfg_in_ch));
		oc = (cfg_out_ch == 5'd0) ? KW'(1) :
			((32'(cfg_out_ch) > MAX_OUT_CHANNELS) ? KW'(MAX_OUT_CHANNELS) : KW'(cfg_out_ch));
		owl = CW'((iw - CW'(3)) >> 1) + CW'(1);
		ohl = RW'((ih - RW'(3)) >> 1) + RW'(1);
		ow = (cfg_out_width == 5'd0) ? CW'(1) :
			((32'(cfg_out_width) > 32'(owl)) ? owl : CW'(cfg_out_width));
		oh = (cfg_out_height == 5'd0) ? RW'(1) :
			((32'(cfg_out_height) > 32'(ohl)) ? ohl : RW'(cfg_out_height));
	end

	// Pixel counters with wrap applied before use.
	logic [CW-1:0] col_q, c_eff;
	logic [RW-1:0] row_q, r_eff;
	logic [QW-1:0] ch_q, q_eff;
	logic [RW-1:0] r_tmp;
	logic [QW-1:0] q_tmp;
	always_comb begin
		c_eff = col_q;
		r_tmp = row_q;
		q_tmp = ch_q;
		if (col_q >= iw) begin
			c_eff = '0;
			r_tmp = row_q + RW'(1);
		end
		r_eff = r_tmp;
		if (r_tmp >= ih) begin
			r_eff = '0;
			q_tmp = ch_q + QW'(1);
		end
		q_eff = (q_tmp >= ic) ? '0 : q_tmp;
	end

	logic [CW-1:0] c_nx;
	logic [RW-1:0] r_nx;
	logic [QW-1:0] q_nx;
	always_comb begin
		c_nx = c_eff + CW'(1);
		r_nx = r_eff;
		q_nx = q_eff;
		if (c_nx >= iw) begin
			c_nx = '0;
			r_nx = r_eff + RW'(1);
			if (r_nx >= ih) begin
				r_nx = '0;
				q_nx = q_eff + QW'(1);
				if (q_nx >= ic) begin
					q_nx = '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			ch_q <= '0;
		end else if (cmd.advance) begin
			col_q <= c_nx;
			row_q <= r_nx;
			ch_q <= q_nx;
		end
	end

	// The accepted pixel is held here until the shift step.
	logic signed [SAMPLE_BITS-1:0] pix_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_q <= '0;
		end else if (cmd.pix_load) begin
			pix_q <= pixel_value;
		end
	end

	// Row buffer: two rows in two separate memories, written during the shift step.
	logic [SAMPLE_BITS-1:0] rbuf_top [MAX_WIDTH];
	logic [SAMPLE_BITS-1:0] rbuf_mid [MAX_WIDTH];
	logic [SAMPLE_BITS-1:0] top_q, mid_q;
	logic [CIW-1:0] cidx;
	assign cidx = c_eff[CIW-1:0];
	always_ff @(posedge clk) begin
		if (cmd.shift) begin
			rbuf_top[cidx] <= mid_q;
			rbuf_mid[cidx] <= pix_q;
		end
	end
	// Read in the idle cycle, while the pixel waits at the input.
	always_ff @(posedge clk) begin
		top_q <= rbuf_top[cidx];
		mid_q <= rbuf_mid[cidx];
	end

	// Window taps, captured on the shift step.
	logic signed [SAMPLE_BITS-1:0] win_q [Taps];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < Taps; i++) begin
				win_q[i] <= '0;
			end
		end else if (cmd.shift) begin
			win_q[0] <= win_q[1];
			win_q[1] <= win_q[2];
			win_q[2] <= top_q;
			win_q[3] <= win_q[4];
			win_q[4] <= win_q[5];
			win_q[5] <= mid_q;
			win_q[6] <= win_q[7];
			win_q[7] <= win_q[8];
			win_q[8] <= pix_q;
		end
	end

	// Position of the current window.
	logic [CW-1:0] xw;
	logic [RW-1:0] yw;
	logic win_ok;
	assign xw = (c_eff - CW'(2)) >> 1;
	assign yw = (r_eff - RW'(2)) >> 1;
	assign win_ok = (r_eff >= RW'(2)) && (c_eff >= CW'(2)) && !r_eff[0] && !c_eff[0]
		&& (xw < ow) && (yw < oh);

	// Weight store.
	logic signed [SAMPLE_BITS-1:0] wmem [WDEPTH];
	logic signed [SAMPLE_BITS-1:0] w_q;
	logic [WAW-1:0] wwaddr, wraddr;
	logic [KIW-1:0] k_q;
	logic [3:0] t_q;
	assign wwaddr = WAW'((32'(weight_out_channel) * MAX_IN_CHANNELS
		+ 32'(weight_in_channel)) * Taps + 32'(weight_tap));
	assign wraddr = WAW'((32'(k_q) * MAX_IN_CHANNELS + 32'(q_eff)) * Taps + 32'(t_q));
	always_ff @(posedge clk) begin
		if (cmd.wr_weight && 32'(weight_out_channel) < MAX_OUT_CHANNELS
			&& 32'(weight_in_channel) < MAX_IN_CHANNELS && weight_tap < 4'(Taps)) begin
			wmem[wwaddr] <= weight_value;
		end
		w_q <= wmem[wraddr];
	end

	// Tap and output-channel sequencing; the weight is read into a register ahead of the MAC.
	logic mac_v_s1, mac_v_s2;
	logic signed [PW-1:0] prod_s2;
	logic signed [SumBits-1:0] dot_q;
	logic signed [SAMPLE_BITS-1:0] px_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t_q <= '0;
			k_q <= '0;
			mac_v_s1 <= 1'b0;
			mac_v_s2 <= 1'b0;
		end else begin
			mac_v_s1 <= cmd.tap_en && (t_q < 4'(Taps));
			mac_v_s2 <= mac_v_s1;
			if (cmd.shift) begin
				k_q <= '0;
			end else if (cmd.acc_wr && !stat.q_last) begin
				k_q <= k_q + KIW'(1);
			end else if (cmd.out_load) begin
				k_q <= k_q + KIW'(1);
			end
			if (cmd.tap_clr) begin
				t_q <= '0;
			end else if (cmd.tap_en && t_q < 4'(Taps)) begin
				t_q <= t_q + 4'd1;
			end
		end
	end
	// The tap is picked in the same cycle as its weight is read.
	always_ff @(posedge clk) begin
		px_s1 <= win_q[t_q];
		prod_s2 <= px_s1 * w_q;
	end
	always_ff @(posedge clk) begin
		if (cmd.tap_clr) begin
			dot_q <= '0;
		end else if (mac_v_s2) begin
			dot_q <= dot_q + SumBits'(prod_s2);
		end
	end
	// All nine taps issue first, then drain_q counts while the product pipeline drains.
	logic [3:0] drain_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drain_q <= '0;
		end else if (!cmd.tap_en) begin
			drain_q <= '0;
		end else if (t_q == 4'(Taps)) begin
			drain_q <= drain_q + 4'd1;
		end
	end

	// Accumulator store.
	logic [SumBits-1:0] amem [ADEPTH];
	logic [SumBits-1:0] acc_rd_q, acc_new;
	logic [AAW-1:0] aaddr;
	assign aaddr = AAW'((32'(k_q) * AR + 32'(yw[YW-1:0])) * AC + 32'(xw[XW-1:0]));
	assign acc_new = (q_eff == '0) ? dot_q : acc_rd_q + dot_q;
	always_ff @(posedge clk) begin
		acc_rd_q <= amem[aaddr];
		if (cmd.acc_wr) begin
			amem[aaddr] <= acc_new;
		end
	end
	logic [SumBits-1:0] res_q;
	always_ff @(posedge clk) begin
		if (cmd.acc_wr) begin
			res_q <= acc_new;
		end
	end

	// Output register.
	logic last_k;
	assign last_k = (32'(k_q) == 32'(oc) - 1);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_channel <= 4'(k_q);
			out_row <= 5'(yw);
			out_col <= 5'(xw);
			sum_value <= res_q;
			last_of_position <= last_k;
			end_of_frame <= last_k && (yw == oh - RW'(1)) && (xw == ow - CW'(1));
		end
	end

	assign stat.window = win_ok;
	assign stat.tap_last = (drain_q == 4'd2);
	assign stat.k_last = last_k;
	assign stat.q_last = (q_eff == ic - QW'(1));
	assign stat.out_busy = out_valid && !out_ready;

endmodule

FILE: hw/rtl/conv3x3_stride2_multichannel.sv
// Channel  | Handshake                | Payload
// in       | in_valid / in_ready      | action, weight_*, pixel_value
// out      | out_valid / out_ready    | out_channel, out_row, out_col, sum_value, flags
// config   | APB write, pready high   | six registers at 4*i
// A weight item is written in the idle state. A pixel item passes the shift and
// advance steps and, for a window inside the output, per output channel nine
// taps through one shared multiplier, a pipeline drain and an accumulator update,
// with an output step on the last input channel. Items are taken only when idle.
// Reset clears counters and window taps; the memories hold no reset value.
// A stalled output holds the sequencer in its output step.
module conv3x3_stride2_multichannel
	import c3s2_pkg::*;
#(
	parameter int MAX_WIDTH = MaxWidthDef,
	parameter int MAX_HEIGHT = MaxHeightDef,
	parameter int MAX_IN_CHANNELS = MaxInChDef,
	parameter int MAX_OUT_CHANNELS = MaxOutChDef,
	parameter int SAMPLE_BITS = SampleBitsDef
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [4:0]                    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          action,
	input  logic [3:0]                    weight_out_channel,
	input  logic [5:0]                    weight_in_channel,
	input  logic [3:0]                    weight_tap,
	input  logic signed [SAMPLE_BITS-1:0] weight_value,
	input  logic signed [SAMPLE_BITS-1:0] pixel_value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [3:0]                    out_channel,
	output logic [4:0]                    out_row,
	output logic [4:0]                    out_col,
	output logic signed [SumBits-1:0]     sum_value,
	output logic                          last_of_position,
	output logic                          end_of_frame
);

	logic [6:0] in_width_q, in_height_q, in_ch_q;
	logic [4:0] out_ch_q, out_width_q, out_height_q;
	logic [2:0] ridx;
	logic       wr;
	ctl_cmd_t   cmd;
	dp_stat_t   stat;

	assign pready = 1'b1;
	assign ridx = paddr[4:2];
	assign wr = psel && penable && pwrite;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_width_q <= 7'd64;
			in_height_q <= 7'd64;
			in_ch_q <= 7'd1;
			out_ch_q <= 5'd1;
			out_width_q <= 5'd31;
			out_height_q <= 5'd31;
		end else if (wr && paddr[1:0] == 2'b00) begin
			case (ridx)
				RegInWidth: in_width_q <= pwdata[6:0];
				RegInHeight: in_height_q <= pwdata[6:0];
				RegInCh: in_ch_q <= pwdata[6:0];
				RegOutCh: out_ch_q <= pwdata[4:0];
				RegOutWidth: out_width_q <= pwdata[4:0];
				RegOutHeight: out_height_q <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	// Register readback.
	always_comb begin
		case (ridx)
			RegInWidth: prdata = {25'd0, in_width_q};
			RegInHeight: prdata = {25'd0, in_height_q};
			RegInCh: prdata = {25'd0, in_ch_q};
			RegOutCh: prdata = {27'd0, out_ch_q};
			RegOutWidth: prdata = {27'd0, out_width_q};
			RegOutHeight: prdata = {27'd0, out_height_q};
			default: prdata = '0;
		endcase
	end

	c3s2_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_action(action),
		.in_ready(in_ready),
		.stat(stat),
		.cmd(cmd)
	);

	c3s2_datapath #(
		.MAX_WIDTH(MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT),
		.MAX_IN_CHANNELS(MAX_IN_CHANNELS),
		.MAX_OUT_CHANNELS(MAX_OUT_CHANNELS),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.stat(stat),
		.cfg_in_width(in_width_q),
		.cfg_in_height(in_height_q),
		.cfg_in_ch(in_ch_q),
		.cfg_out_ch(out_ch_q),
		.cfg_out_width(out_width_q),
		.cfg_out_height(out_height_q),
		.weight_out_channel(weight_out_channel),
		.weight_in_channel(weight_in_channel),
		.weight_tap(weight_tap),
		.weight_value(weight_value),
		.pixel_value(pixel_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_channel(out_channel),
		.out_row(out_row),
		.out_col(out_col),
		.sum_value(sum_value),
		.last_of_position(last_of_position),
		.end_of_frame(end_of_frame)
	);

endmodule
